// ----- hw/rtl/ffpm_pkg.sv -----
`default_nettype none
package ffpm_pkg;
	localparam int unsigned FLOW_SCALE = 14062500;
	localparam int unsigned NUM_REGS = 6;

	typedef enum logic [2:0] {
		REG_ML_PER_PULSE = 3'd0,
		REG_MIN_GAP      = 3'd1,
		REG_IDLE_TIMEOUT = 3'd2,
		REG_EMPTY_LIMIT  = 3'd3,
		REG_HOLDOFF      = 3'd4,
		REG_MIN_SPEED    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pulse;
		logic read_prep;
		logic mul;
		logic div_start;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic report;
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic        op;
		logic [31:0] time_us;
		logic        spraying;
		logic [15:0] ground_speed_cms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] flow_ml_per_hour;
		logic [47:0] consumed_ml_q8;
		logic [31:0] total_pulses;
		logic [23:0] period_pulses;
		logic        tank_empty_alarm;
	} out_item_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ffpm_if.sv -----
`default_nettype none
interface ffpm_in_if;
	logic               valid;
	logic               ready;
	ffpm_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffpm_out_if;
	logic                valid;
	logic                ready;
	ffpm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ffpm_ctrl.sv -----
`default_nettype none
module ffpm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire ffpm_pkg::stat_t stat,
	output ffpm_pkg::cmd_t     cmd
);
	ffpm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ffpm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ffpm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_op) cmd.pulse = 1'b1;
					else begin
						cmd.read_prep = 1'b1;
						state_d = ffpm_pkg::ST_MUL;
					end
				end
			end
			ffpm_pkg::ST_MUL: begin
				if (stat.report) begin
					cmd.mul = 1'b1;
					state_d = ffpm_pkg::ST_DIV;
				end else state_d = ffpm_pkg::ST_IDLE;
			end
			ffpm_pkg::ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d = ffpm_pkg::ST_UPDATE;
			end
			ffpm_pkg::ST_UPDATE: begin
				if (stat.div_done) begin
					cmd.update = 1'b1;
					state_d = ffpm_pkg::ST_OUT;
				end
			end
			ffpm_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ffpm_pkg::ST_IDLE;
			end
			default: state_d = ffpm_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/ffpm_div.sv -----
`default_nettype none
// restoring divider, 64 by 32 bits, one quotient bit a cycle
module ffpm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= 7'd64;
		else if (cnt_q != '0) cnt_q <= cnt_q - 7'd1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ffpm_dp.sv -----
`default_nettype none
module ffpm_dp #(
	parameter int HISTORY_DEPTH = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffpm_pkg::cmd_t     cmd,
	output ffpm_pkg::stat_t         stat,
	input  wire ffpm_pkg::in_item_t in_data,
	input  wire logic [15:0]        ml_per_pulse,
	input  wire logic [9:0]         min_gap,
	input  wire logic [31:0]        idle_timeout,
	input  wire logic [7:0]         empty_limit,
	input  wire logic [31:0]        holdoff,
	input  wire logic [15:0]        min_speed,
	output ffpm_pkg::out_item_t     out_data
);
	localparam int IW = $clog2(HISTORY_DEPTH);

	logic        pulse_seen_q, read_started_q, history_full_q, holdoff_started_q;
	logic [31:0] last_pulse_q, gap_sum_q, last_read_q, pulse_total_q, last_alarm_q;
	logic [23:0] counter_q;
	logic [47:0] consumed_q;
	logic [7:0]  hist_q [HISTORY_DEPTH];
	logic [IW-1:0] hidx_q;
	logic        report_q;
	// latched read item
	logic [31:0] rt_q, gap_q;
	logic [23:0] cnt_q;
	logic        rec_q;
	logic [39:0] vol_q;
	logic [63:0] prod;
	logic        div_start_q;
	logic        div_busy;
	logic [63:0] quo;

	logic [31:0] pdelta, rdelta, adelta;
	logic [32:0] gsum;
	assign pdelta = in_data.time_us - last_pulse_q;
	assign rdelta = in_data.time_us - last_read_q;
	assign gsum = {1'b0, gap_sum_q} + {1'b0, pdelta};

	// volume times flow scale, taken by the divider as it starts
	assign prod = {24'd0, vol_q} * 64'(ffpm_pkg::FLOW_SCALE);

	ffpm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(prod), .divisor(gap_q), .busy(div_busy), .quotient(quo)
	);

	always_ff @(posedge clk) div_start_q <= cmd.div_start;
	assign stat.div_done = !div_busy && !div_start_q;
	assign stat.report = report_q;

	// history update and empty check, used at update time
	logic [IW-1:0] hidx_n;
	logic          full_n, empty;
	logic [7:0]    hval;
	logic [7:0]    hnew [HISTORY_DEPTH];
	assign hval = (cnt_q > 24'd255) ? 8'd255 : cnt_q[7:0];
	assign hidx_n = (hidx_q == IW'(HISTORY_DEPTH - 1)) ? '0 : hidx_q + 1'b1;
	assign full_n = history_full_q || (hidx_n == '0);
	always_comb begin
		empty = full_n;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			hnew[i] = (IW'(i) == hidx_q) ? hval : hist_q[i];
			if (hnew[i] > empty_limit) empty = 1'b0;
		end
	end
	logic [31:0] alarm_ref;
	assign alarm_ref = holdoff_started_q ? last_alarm_q : rt_q;
	assign adelta = rt_q - alarm_ref;

	logic [48:0] vsum;
	logic [32:0] tsum;
	assign vsum = {1'b0, consumed_q} + {9'd0, vol_q};
	assign tsum = {1'b0, pulse_total_q} + {9'd0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_seen_q <= 1'b0; read_started_q <= 1'b0;
			history_full_q <= 1'b0; holdoff_started_q <= 1'b0;
			last_pulse_q <= '0; gap_sum_q <= '0; last_read_q <= '0;
			pulse_total_q <= '0; last_alarm_q <= '0; counter_q <= '0;
			consumed_q <= '0; hidx_q <= '0; report_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			if (cmd.pulse) begin
				if (!pulse_seen_q) begin
					pulse_seen_q <= 1'b1;
					last_pulse_q <= in_data.time_us;
				end else if (pdelta >= {22'd0, min_gap}) begin
					if (counter_q != '1) counter_q <= counter_q + 24'd1;
					gap_sum_q <= gsum[32] ? '1 : gsum[31:0];
					last_pulse_q <= in_data.time_us;
				end
			end
			if (cmd.read_prep) begin
				report_q <= 1'b0;
				if (!read_started_q) begin
					read_started_q <= 1'b1;
					last_read_q <= in_data.time_us;
				end else if (!(rdelta < idle_timeout && counter_q == '0)) begin
					report_q <= 1'b1;
					counter_q <= '0;
					gap_sum_q <= '0;
					last_read_q <= in_data.time_us;
				end
			end
			if (cmd.update) begin
				consumed_q <= vsum[48] ? '1 : vsum[47:0];
				pulse_total_q <= tsum[32] ? '1 : tsum[31:0];
				if (rec_q) begin
					hist_q <= hnew;
					hidx_q <= hidx_n;
					history_full_q <= full_n;
					holdoff_started_q <= 1'b1;
					if (empty && adelta > holdoff) last_alarm_q <= rt_q;
					else last_alarm_q <= alarm_ref;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_prep) begin
			rt_q <= in_data.time_us;
			cnt_q <= counter_q;
			gap_q <= gap_sum_q;
			rec_q <= in_data.spraying && (in_data.ground_speed_cms >= min_speed);
		end
		if (cmd.mul) vol_q <= {16'd0, cnt_q} * {24'd0, ml_per_pulse};
		if (cmd.update) begin
			if (vol_q == '0) out_data.flow_ml_per_hour <= '0;
			else if (gap_q == '0 || quo[63:32] != '0) out_data.flow_ml_per_hour <= '1;
			else out_data.flow_ml_per_hour <= quo[31:0];
			out_data.consumed_ml_q8 <= vsum[48] ? '1 : vsum[47:0];
			out_data.total_pulses <= tsum[32] ? '1 : tsum[31:0];
			out_data.period_pulses <= cnt_q;
			out_data.tank_empty_alarm <= rec_q && empty && (adelta > holdoff);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fuel_flow_pulse_monitor_unit.sv -----
`default_nettype none
// Fuel flow pulse monitor.
// Input channel in: op 0 is a pulse edge, op 1 a read tick, with a timestamp.
// Output channel out: one item for each reported read (flow, volume, totals,
// tank-empty alarm). Pulses and unreported reads give nothing.
// A pulse item does not leave the idle state: the block stays ready.
// A reported read goes through a 16x24 multiply, a multiply by the flow
// scale, then a 64-bit restoring divide at one quotient bit a cycle, and
// no new item is taken until its result has been taken. A read that is
// not reported returns to idle with no output.
// The result waits in the output register until taken; no new item is taken
// while it waits (the receiver stalls the input).
// Registers are written over the APB port at byte address 4*index.
// Reset clears all counters, history and timing state and loads the
// register defaults; the block is ready right after reset.
module fuel_flow_pulse_monitor_unit #(
	parameter int HISTORY_DEPTH = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ffpm_in_if.sink          in,
	ffpm_out_if.source       out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [15:0] ml_q, speed_q;
	logic [9:0]  gap_q;
	logic [31:0] idle_q, hold_q;
	logic [7:0]  lim_q;
	logic        wr;
	ffpm_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = ffpm_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q <= 16'd256; gap_q <= 10'd10; idle_q <= 32'd1000000;
			lim_q <= 8'd2; hold_q <= 32'd2000000; speed_q <= 16'd100;
		end else if (wr) begin
			case (ridx)
				ffpm_pkg::REG_ML_PER_PULSE: ml_q <= pwdata[15:0];
				ffpm_pkg::REG_MIN_GAP:      gap_q <= pwdata[9:0];
				ffpm_pkg::REG_IDLE_TIMEOUT: idle_q <= pwdata;
				ffpm_pkg::REG_EMPTY_LIMIT:  lim_q <= pwdata[7:0];
				ffpm_pkg::REG_HOLDOFF:      hold_q <= pwdata;
				ffpm_pkg::REG_MIN_SPEED:    speed_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			ffpm_pkg::REG_ML_PER_PULSE: prdata = {16'd0, ml_q};
			ffpm_pkg::REG_MIN_GAP:      prdata = {22'd0, gap_q};
			ffpm_pkg::REG_IDLE_TIMEOUT: prdata = idle_q;
			ffpm_pkg::REG_EMPTY_LIMIT:  prdata = {24'd0, lim_q};
			ffpm_pkg::REG_HOLDOFF:      prdata = hold_q;
			ffpm_pkg::REG_MIN_SPEED:    prdata = {16'd0, speed_q};
			default:                    prdata = '0;
		endcase
	end

	ffpm_pkg::cmd_t  cmd;
	ffpm_pkg::stat_t stat;

	ffpm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_op(in.data.op),
		.in_ready(in.ready), .out_valid(out.valid), .out_ready(out.ready),
		.stat(stat), .cmd(cmd)
	);

	ffpm_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_data(in.data),
		.ml_per_pulse(ml_q), .min_gap(gap_q), .idle_timeout(idle_q),
		.empty_limit(lim_q), .holdoff(hold_q), .min_speed(speed_q),
		.out_data(out.data)
	);

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !in.ready) else $error("input taken while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.data))
		else $error("result changed under stall");
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready && in.data.op |=> !in.ready)
		else $error("read item did not hold input");
endmodule
`default_nettype wire
